@@ design/shortest_path_single_source_defines.svh @@
// Assertion macros shared by the shortest path block.
// Included by the top level; the enclosing module must provide clk and rst.
`ifndef SHORTEST_PATH_SINGLE_SOURCE_DEFINES_SVH
`define SHORTEST_PATH_SINGLE_SOURCE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spss check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spss check failed");

`endif

@@ design/spss_pkg.sv @@
// Shared types and constants for the shortest path block.
// Used by the edge memory, the node memory and the top level; no dependencies.
package spss_pkg;

  localparam int MAX_NODES = 32;
  localparam int MAX_EDGES = 128;
  localparam int NODE_W = 5;
  localparam int NCNT_W = 6;
  localparam int EDGE_AW = 7;
  localparam int ECNT_W = 8;
  localparam int DIST_W = 17;
  localparam int TIME_W = 12;

  // Predecessor code with bit 5 set means no predecessor.
  localparam logic [NCNT_W-1:0] NO_PRED = 6'h20;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] road_end_a;
    logic [NODE_W-1:0] road_end_b;
    logic [TIME_W-1:0] road_time;
    logic [NODE_W-1:0] source_node;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [DIST_W-1:0] distance;
    logic [NODE_W-1:0] predecessor;
    logic              has_predecessor;
    logic              reachable;
    logic [1:0]        status;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] end_a;
    logic [NODE_W-1:0] end_b;
    logic [TIME_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [DIST_W-1:0] path_len;
    logic [NCNT_W-1:0] from;
    logic              finished;
    logic              reached;
  } node_t;

endpackage

@@ design/spss_edge_mem.sv @@
// Road store: one write port, one registered read port.
// Depends on spss_pkg for the entry type and depth.
module spss_edge_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [spss_pkg::EDGE_AW-1:0] waddr,
  input  spss_pkg::edge_t              wdata,
  input  logic [spss_pkg::EDGE_AW-1:0] raddr,
  output spss_pkg::edge_t              rdata
);

  spss_pkg::edge_t mem [spss_pkg::MAX_EDGES];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/spss_node_mem.sv @@
// Per-node working memory with a registered read port.
// A read of the entry written in the same cycle returns the new data.
// Depends on spss_pkg for the entry type and depth.
module spss_node_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [spss_pkg::NODE_W-1:0] waddr,
  input  spss_pkg::node_t             wdata,
  input  logic [spss_pkg::NODE_W-1:0] raddr,
  output spss_pkg::node_t             rdata
);

  spss_pkg::node_t mem [spss_pkg::MAX_NODES];

  // Write, and read with write-through forwarding.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/shortest_path_single_source.sv @@
// Single-source shortest paths over a stored road list, one node memory port.
// An add word gives its status word in the cycle after acceptance; the next word is taken
// once that result word has left. Output stalls hold up a compute word; one word at a time.
// Reset clears control state and the road count and sets node_count to 32; no clearing pass.
module shortest_path_single_source (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  spss_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output spss_pkg::out_word_t out_word,
  input  logic                cfg_write_en,
  input  logic [5:0]          cfg_write_data
);

  `include "shortest_path_single_source_defines.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_MARK = 3'd3;
  localparam logic [2:0] ST_RELAX = 3'd4;
  localparam logic [2:0] ST_OUT_RD = 3'd5;
  localparam logic [2:0] ST_OUT_LD = 3'd6;

  logic [2:0]                  state;
  logic [5:0]                  node_count;
  logic [spss_pkg::ECNT_W-1:0] edges_stored;
  logic [spss_pkg::NCNT_W-1:0] act_n;
  logic [spss_pkg::NCNT_W-1:0] icnt;
  logic [spss_pkg::ECNT_W-1:0] ecnt;
  logic [spss_pkg::NODE_W-1:0] src;
  logic                        in_acc;
  logic                        add_ok;

  // Scan and current best node.
  logic                        sv;
  logic [spss_pkg::NODE_W-1:0] sidx;
  logic                        found;
  logic [spss_pkg::NODE_W-1:0] bu;
  logic [spss_pkg::DIST_W-1:0] bd;
  logic [spss_pkg::NCNT_W-1:0] bfrom;

  // Relaxation pipeline.
  logic                        r1v;
  logic                        r2v;
  logic [spss_pkg::NODE_W-1:0] r2nb;
  logic [spss_pkg::DIST_W-1:0] r2nd;
  logic                        r1hit;
  logic [spss_pkg::NODE_W-1:0] r1nb;

  logic                        em_we;
  spss_pkg::edge_t             em_wdata;
  logic [spss_pkg::EDGE_AW-1:0] em_raddr;
  spss_pkg::edge_t             em_rdata;
  logic                        nm_we;
  logic [spss_pkg::NODE_W-1:0] nm_waddr;
  spss_pkg::node_t             nm_wdata;
  logic [spss_pkg::NODE_W-1:0] nm_raddr;
  spss_pkg::node_t             nm_rdata;

  // Single result word for an add or a rejected compute.
  function automatic spss_pkg::out_word_t status_word(input logic [1:0] code);
    spss_pkg::out_word_t w;
    w = '0;
    w.status = code;
    w.last = 1'b1;
    return w;
  endfunction

  // Active node count, clamped to the legal range.
  always_comb begin
    if (node_count == '0) begin
      act_n = 6'd1;
    end else if (node_count > 6'(spss_pkg::MAX_NODES)) begin
      act_n = 6'(spss_pkg::MAX_NODES);
    end else begin
      act_n = node_count;
    end
  end

  // A new word is taken only in idle with the result register empty.
  assign in_stall = (state != ST_IDLE) || out_valid;
  assign in_acc = in_valid && !in_stall;
  assign add_ok = ({1'b0, in_word.road_end_a} < act_n) && ({1'b0, in_word.road_end_b} < act_n)
                  && (edges_stored < 8'(spss_pkg::MAX_EDGES));

  // Road store write on an accepted add word.
  assign em_we = in_acc && (in_word.mode == spss_pkg::MODE_ADD) && add_ok;
  assign em_wdata = '{end_a: in_word.road_end_a, end_b: in_word.road_end_b,
                      weight: in_word.road_time};
  assign em_raddr = ecnt[spss_pkg::EDGE_AW-1:0];

  spss_edge_mem u_edge_mem (
    .clk   (clk),
    .we    (em_we),
    .waddr (edges_stored[spss_pkg::EDGE_AW-1:0]),
    .wdata (em_wdata),
    .raddr (em_raddr),
    .rdata (em_rdata)
  );

  // Does the road just read touch the node being finished, and where does it lead.
  always_comb begin
    r1hit = 1'b0;
    r1nb = em_rdata.end_b;
    if (({1'b0, em_rdata.end_a} < act_n) && ({1'b0, em_rdata.end_b} < act_n)) begin
      if (em_rdata.end_a == bu) begin
        r1hit = 1'b1;
        r1nb = em_rdata.end_b;
      end else if (em_rdata.end_b == bu) begin
        r1hit = 1'b1;
        r1nb = em_rdata.end_a;
      end
    end
  end

  // Node memory port control.
  always_comb begin
    nm_we = 1'b0;
    nm_waddr = icnt[spss_pkg::NODE_W-1:0];
    nm_wdata = '{path_len: '0, from: spss_pkg::NO_PRED, finished: 1'b0,
                 reached: (icnt[spss_pkg::NODE_W-1:0] == src)};
    nm_raddr = icnt[spss_pkg::NODE_W-1:0];
    case (state)
      ST_INIT: begin
        nm_we = 1'b1;
      end
      ST_MARK: begin
        nm_we = 1'b1;
        nm_waddr = bu;
        nm_wdata = '{path_len: bd, from: bfrom, finished: 1'b1, reached: 1'b1};
      end
      ST_RELAX: begin
        nm_raddr = r1nb;
        nm_waddr = r2nb;
        nm_wdata = '{path_len: r2nd, from: {1'b0, bu}, finished: nm_rdata.finished,
                     reached: 1'b1};
        nm_we = r2v && (!nm_rdata.reached || (r2nd < nm_rdata.path_len));
      end
      default: begin
      end
    endcase
  end

  spss_node_mem u_node_mem (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (nm_raddr),
    .rdata (nm_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      node_count <= 6'd32;
      edges_stored <= '0;
      out_valid <= 1'b0;
      sv <= 1'b0;
      found <= 1'b0;
      r1v <= 1'b0;
      r2v <= 1'b0;
      icnt <= '0;
      ecnt <= '0;
    end else begin
      if (cfg_write_en) begin
        node_count <= cfg_write_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_word.mode == spss_pkg::MODE_ADD) begin
              out_valid <= 1'b1;
              if (({1'b0, in_word.road_end_a} >= act_n)
                  || ({1'b0, in_word.road_end_b} >= act_n)) begin
                out_word <= status_word(spss_pkg::STATUS_RANGE);
              end else if (edges_stored >= 8'(spss_pkg::MAX_EDGES)) begin
                out_word <= status_word(spss_pkg::STATUS_FULL);
              end else begin
                out_word <= status_word(spss_pkg::STATUS_OK);
                edges_stored <= edges_stored + 8'd1;
              end
            end else if ({1'b0, in_word.source_node} >= act_n) begin
              out_valid <= 1'b1;
              out_word <= status_word(spss_pkg::STATUS_RANGE);
            end else begin
              src <= in_word.source_node;
              icnt <= '0;
              state <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          if (icnt + 6'd1 == act_n) begin
            icnt <= '0;
            sv <= 1'b0;
            found <= 1'b0;
            state <= ST_SCAN;
          end else begin
            icnt <= icnt + 6'd1;
          end
        end
        ST_SCAN: begin
          // Issue reads in index order and keep the least reached, unfinished node.
          if (icnt < act_n) begin
            icnt <= icnt + 6'd1;
            sv <= 1'b1;
            sidx <= icnt[spss_pkg::NODE_W-1:0];
          end else begin
            sv <= 1'b0;
          end
          if (sv && nm_rdata.reached && !nm_rdata.finished
              && (!found || (nm_rdata.path_len < bd))) begin
            found <= 1'b1;
            bu <= sidx;
            bd <= nm_rdata.path_len;
            bfrom <= nm_rdata.from;
          end
          if ((icnt >= act_n) && !sv) begin
            icnt <= '0;
            state <= found ? ST_MARK : ST_OUT_RD;
          end
        end
        ST_MARK: begin
          ecnt <= '0;
          r1v <= 1'b0;
          r2v <= 1'b0;
          state <= ST_RELAX;
        end
        ST_RELAX: begin
          // Road read, neighbor read, then compare and write back.
          if (ecnt < edges_stored) begin
            ecnt <= ecnt + 8'd1;
            r1v <= 1'b1;
          end else begin
            r1v <= 1'b0;
          end
          r2v <= r1v && r1hit;
          r2nb <= r1nb;
          r2nd <= bd + {5'd0, em_rdata.weight};
          if ((ecnt >= edges_stored) && !r1v && !r2v) begin
            icnt <= '0;
            sv <= 1'b0;
            found <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_OUT_RD: begin
          if (!out_valid || !out_stall) begin
            state <= ST_OUT_LD;
          end
        end
        ST_OUT_LD: begin
          out_valid <= 1'b1;
          out_word <= '{
            node_index: icnt[spss_pkg::NODE_W-1:0],
            distance: nm_rdata.reached ? nm_rdata.path_len : '0,
            predecessor: (nm_rdata.reached && !nm_rdata.from[spss_pkg::NODE_W])
                         ? nm_rdata.from[spss_pkg::NODE_W-1:0] : '0,
            has_predecessor: nm_rdata.reached && !nm_rdata.from[spss_pkg::NODE_W],
            reachable: nm_rdata.reached,
            status: spss_pkg::STATUS_OK,
            last: (icnt + 6'd1 == act_n)
          };
          icnt <= icnt + 6'd1;
          state <= (icnt + 6'd1 == act_n) ? ST_IDLE : ST_OUT_RD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer.
  `SPSS_ASSERT_NOW(a_busy_stalls, state != ST_IDLE, in_stall)
  `SPSS_ASSERT_NOW(a_store_bound, 1'b1, edges_stored <= 8'(spss_pkg::MAX_EDGES))
  `SPSS_ASSERT_NOW(a_relax_write, (state == ST_RELAX) && nm_we, r2v)
  `SPSS_ASSERT_NEXT(a_out_load, state == ST_OUT_LD, out_valid)

endmodule
